>>> hw/rtl/ppr_pkg.sv
// shared types and constants for the polygon point-region classifier
// used by every module and interface of the block; no dependencies
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CMD_W        = 2;
    localparam int REGION_W     = 2;
    localparam int MIN_POLY_VERTICES = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_CLASSIFY = 2'd2
    } cmd_t;

    localparam logic [REGION_W-1:0] REGION_OUTSIDE_BOX = 2'd0;
    localparam logic [REGION_W-1:0] REGION_IN_BOX      = 2'd1;
    localparam logic [REGION_W-1:0] REGION_INSIDE      = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // per-token control carried down the edge pipeline
    typedef struct packed {
        logic last;        // final token of its item, produces the result
        logic tested;      // point was in the box, parity decides the region
        logic poly_valid;
        logic status;
    } tag_t;

    // test point and the two end vertices of one edge
    typedef struct packed {
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [COORD_W-1:0] xi;
        logic [COORD_W-1:0] yi;
        logic [COORD_W-1:0] xj;
        logic [COORD_W-1:0] yj;
    } edge_pts_t;

endpackage

>>> hw/rtl/ppr_in_if.sv
// input channel of the classifier: command and point coordinates
// depends on ppr_pkg
`timescale 1ns / 1ps

interface ppr_in_if;
    logic                                valid;
    logic                                ready;
    logic [ppr_pkg::CMD_W-1:0]           command;
    logic signed [ppr_pkg::COORD_W-1:0]  point_x;
    logic signed [ppr_pkg::COORD_W-1:0]  point_y;

    modport source (output valid, output command, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input command, input point_x, input point_y,
                    output ready);
endinterface

>>> hw/rtl/ppr_out_if.sv
// result channel of the classifier: region, polygon valid flag, status
// depends on ppr_pkg
`timescale 1ns / 1ps

interface ppr_out_if;
    logic                           valid;
    logic                           ready;
    logic [ppr_pkg::REGION_W-1:0]   region;
    logic                           polygon_valid;
    logic                           status;

    modport source (output valid, output region, output polygon_valid, output status,
                    input ready);
    modport sink   (input valid, input region, input polygon_valid, input status,
                    output ready);
endinterface

>>> hw/rtl/ppr_issue.sv
// front end: polygon state, vertex store, bounding box and edge sequencer
// issues one edge token per cycle into the pipeline unless stalled; depends on ppr_pkg, ppr_in_if
`timescale 1ns / 1ps

module ppr_issue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    ppr_in_if.sink                     query,
    output logic                       s1_valid,
    output ppr_pkg::tag_t              s1_tag,
    output ppr_pkg::edge_pts_t         s1_pts
);

    // polygon state
    logic [ppr_pkg::CNT_W-1:0]          count_reg, count_next;
    logic signed [ppr_pkg::COORD_W-1:0] min_x_reg, min_x_next;
    logic signed [ppr_pkg::COORD_W-1:0] max_x_reg, max_x_next;
    logic signed [ppr_pkg::COORD_W-1:0] min_y_reg, min_y_next;
    logic signed [ppr_pkg::COORD_W-1:0] max_y_reg, max_y_next;
    logic [ppr_pkg::COORD_W-1:0]        last_x_reg;
    logic [ppr_pkg::COORD_W-1:0]        last_y_reg;

    logic [ppr_pkg::COORD_W-1:0] vertex_x_mem [ppr_pkg::MAX_VERTICES];
    logic [ppr_pkg::COORD_W-1:0] vertex_y_mem [ppr_pkg::MAX_VERTICES];
    logic [ppr_pkg::COORD_W-1:0] rd_x_reg;
    logic [ppr_pkg::COORD_W-1:0] rd_y_reg;

    // item being issued
    logic                        cmd_valid_reg;
    ppr_pkg::tag_t               cmd_tag_reg;
    logic [ppr_pkg::COORD_W-1:0] cmd_x_reg;
    logic [ppr_pkg::COORD_W-1:0] cmd_y_reg;
    logic [ppr_pkg::CNT_W-1:0]   cmd_cnt_reg;
    logic [ppr_pkg::ADDR_W-1:0]  idx_reg;

    // stage 1 registers
    logic                        s1_valid_reg;
    ppr_pkg::tag_t               s1_tag_reg, s1_tag_next;
    logic [ppr_pkg::COORD_W-1:0] s1_tx_reg;
    logic [ppr_pkg::COORD_W-1:0] s1_ty_reg;
    logic [ppr_pkg::COORD_W-1:0] s1_xj_reg;
    logic [ppr_pkg::COORD_W-1:0] s1_yj_reg;

    ppr_pkg::cmd_t cmd;
    logic          accept;
    logic          cmd_last;
    logic          full;
    logic          append_ok;
    logic          in_box;
    ppr_pkg::tag_t new_tag;

    assign cmd       = ppr_pkg::cmd_t'(query.command);
    assign cmd_last  = !cmd_tag_reg.tested
                    || ({1'b0, idx_reg} == cmd_cnt_reg - ppr_pkg::CNT_W'(1));
    assign query.ready = en && (!cmd_valid_reg || cmd_last);
    assign accept    = query.valid && query.ready;
    assign full      = (count_reg == ppr_pkg::CNT_W'(ppr_pkg::MAX_VERTICES));
    assign append_ok = accept && (cmd == ppr_pkg::CMD_APPEND) && !full;

    assign in_box = (count_reg != '0)
                 && (query.point_x >= min_x_reg) && (query.point_x <= max_x_reg)
                 && (query.point_y >= min_y_reg) && (query.point_y <= max_y_reg);

    always_comb
    begin
        count_next = count_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (accept)
        begin
            case (cmd)
                ppr_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                    min_x_next = '0;
                    max_x_next = '0;
                    min_y_next = '0;
                    max_y_next = '0;
                end
                ppr_pkg::CMD_APPEND:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + ppr_pkg::CNT_W'(1);
                        if (count_reg == '0)
                        begin
                            min_x_next = query.point_x;
                            max_x_next = query.point_x;
                            min_y_next = query.point_y;
                            max_y_next = query.point_y;
                        end
                        else
                        begin
                            if (query.point_x < min_x_reg) min_x_next = query.point_x;
                            if (query.point_x > max_x_reg) max_x_next = query.point_x;
                            if (query.point_y < min_y_reg) min_y_next = query.point_y;
                            if (query.point_y > max_y_reg) max_y_next = query.point_y;
                        end
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        new_tag.last       = 1'b0;
        new_tag.tested     = (cmd == ppr_pkg::CMD_CLASSIFY) && in_box;
        new_tag.poly_valid = (count_next >= ppr_pkg::CNT_W'(ppr_pkg::MIN_POLY_VERTICES));
        new_tag.status     = ((cmd == ppr_pkg::CMD_APPEND) && full)
                           ? ppr_pkg::STATUS_DROPPED : ppr_pkg::STATUS_OK;
    end

    // token tag with its end-of-item mark
    always_comb
    begin
        s1_tag_next      = cmd_tag_reg;
        s1_tag_next.last = cmd_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
        end
    end

    // last stored vertex closes the ring for edge zero
    always_ff @(posedge clk)
    begin
        if (append_ok)
        begin
            last_x_reg <= query.point_x;
            last_y_reg <= query.point_y;
        end
    end

    // vertex store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (append_ok)
        begin
            vertex_x_mem[count_reg[ppr_pkg::ADDR_W-1:0]] <= query.point_x;
            vertex_y_mem[count_reg[ppr_pkg::ADDR_W-1:0]] <= query.point_y;
        end
        if (en)
        begin
            rd_x_reg <= vertex_x_mem[idx_reg];
            rd_y_reg <= vertex_y_mem[idx_reg];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                cmd_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (cmd_valid_reg && cmd_last)
            begin
                cmd_valid_reg <= 1'b0;
            end
            else if (cmd_valid_reg)
            begin
                idx_reg <= idx_reg + ppr_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_tag_reg <= new_tag;
            cmd_x_reg   <= query.point_x;
            cmd_y_reg   <= query.point_y;
            cmd_cnt_reg <= count_reg;
        end
    end

    // stage 1: edge token with its previous vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tag_reg      <= s1_tag_next;
            s1_tx_reg       <= cmd_x_reg;
            s1_ty_reg       <= cmd_y_reg;
            s1_xj_reg       <= (idx_reg == '0) ? last_x_reg : rd_x_reg;
            s1_yj_reg       <= (idx_reg == '0) ? last_y_reg : rd_y_reg;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_tag    = s1_tag_reg;
    assign s1_pts.tx = s1_tx_reg;
    assign s1_pts.ty = s1_ty_reg;
    assign s1_pts.xi = rd_x_reg;
    assign s1_pts.yi = rd_y_reg;
    assign s1_pts.xj = s1_xj_reg;
    assign s1_pts.yj = s1_yj_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppr_pkg::CNT_W'(ppr_pkg::MAX_VERTICES))
        else $error("vertex count above store depth");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && cmd_tag_reg.tested |-> ({1'b0, idx_reg} < cmd_cnt_reg))
        else $error("edge index beyond vertex count of item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(idx_reg) && $stable(count_reg) && $stable(cmd_valid_reg))
        else $error("sequencer moved during stall");
`endif

endmodule

>>> hw/rtl/ppr_edge.sv
// edge crossing pipeline: differences, exact cross products, crossing decision
// three register stages; depends on ppr_pkg
`timescale 1ns / 1ps

module ppr_edge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                s1_valid,
    input  ppr_pkg::tag_t       s1_tag,
    input  ppr_pkg::edge_pts_t  s1_pts,
    output logic                s4_valid,
    output ppr_pkg::tag_t       s4_tag,
    output logic                s4_cross
);

    logic signed [ppr_pkg::COORD_W-1:0] tx, ty, xi, yi, xj, yj;

    logic                              s2_valid_reg;
    ppr_pkg::tag_t                     s2_tag_reg;
    logic signed [ppr_pkg::DIFF_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic                              s2_straddle_reg;
    logic                              s2_dy_pos_reg;

    logic                              s3_valid_reg;
    ppr_pkg::tag_t                     s3_tag_reg;
    logic signed [ppr_pkg::PROD_W-1:0] p1_reg, p2_reg;
    logic                              s3_straddle_reg;
    logic                              s3_dy_pos_reg;

    logic                              s4_valid_reg;
    ppr_pkg::tag_t                     s4_tag_reg;
    logic                              s4_cross_reg;

    assign tx = $signed(s1_pts.tx);
    assign ty = $signed(s1_pts.ty);
    assign xi = $signed(s1_pts.xi);
    assign yi = $signed(s1_pts.yi);
    assign xj = $signed(s1_pts.xj);
    assign yj = $signed(s1_pts.yj);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 2: edge deltas, sign-extended so nothing wraps
            s2_tag_reg      <= s1_tag;
            a_reg           <= ppr_pkg::DIFF_W'(tx) - ppr_pkg::DIFF_W'(xi);
            b_reg           <= ppr_pkg::DIFF_W'(yj) - ppr_pkg::DIFF_W'(yi);
            c_reg           <= ppr_pkg::DIFF_W'(xj) - ppr_pkg::DIFF_W'(xi);
            d_reg           <= ppr_pkg::DIFF_W'(ty) - ppr_pkg::DIFF_W'(yi);
            s2_straddle_reg <= (yi > ty) != (yj > ty);
            s2_dy_pos_reg   <= yj > yi;

            // stage 3: (tx-xi)*dy against (xj-xi)*(ty-yi)
            s3_tag_reg      <= s2_tag_reg;
            p1_reg          <= a_reg * b_reg;
            p2_reg          <= c_reg * d_reg;
            s3_straddle_reg <= s2_straddle_reg;
            s3_dy_pos_reg   <= s2_dy_pos_reg;

            // stage 4: ray crosses the edge, sign of dy flips the compare
            s4_tag_reg   <= s3_tag_reg;
            s4_cross_reg <= s3_straddle_reg
                         && (s3_dy_pos_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg));
        end
    end

    assign s4_valid = s4_valid_reg;
    assign s4_tag   = s4_tag_reg;
    assign s4_cross = s4_cross_reg;

endmodule

>>> hw/rtl/ppr_collect.sv
// even-odd accumulator and result register, source of the pipeline enable
// depends on ppr_pkg, ppr_out_if
`timescale 1ns / 1ps

module ppr_collect (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s4_valid,
    input  ppr_pkg::tag_t   s4_tag,
    input  logic            s4_cross,
    output logic            en,
    ppr_out_if.source       answer
);

    logic                         odd_reg;
    logic                         odd_final;
    logic                         out_valid_reg;
    logic [ppr_pkg::REGION_W-1:0] region_reg;
    logic                         poly_valid_reg;
    logic                         status_reg;

    assign en        = !out_valid_reg || answer.ready;
    assign odd_final = odd_reg ^ s4_cross;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            odd_reg       <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s4_valid && s4_tag.last;
            if (s4_valid)
                odd_reg <= s4_tag.last ? 1'b0 : odd_final;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s4_valid && s4_tag.last)
        begin
            if (!s4_tag.tested)
                region_reg <= ppr_pkg::REGION_OUTSIDE_BOX;
            else if (odd_final)
                region_reg <= ppr_pkg::REGION_INSIDE;
            else
                region_reg <= ppr_pkg::REGION_IN_BOX;
            poly_valid_reg <= s4_tag.poly_valid;
            status_reg     <= s4_tag.status;
        end
    end

    assign answer.valid         = out_valid_reg;
    assign answer.region        = region_reg;
    assign answer.polygon_valid = poly_valid_reg;
    assign answer.status        = status_reg;

`ifndef SYNTHESIS
    a_parity_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        en && s4_valid && s4_tag.last |=> !odd_reg)
        else $error("crossing parity not cleared after item");
`endif

endmodule

>>> hw/rtl/polygon_point_region_classifier.sv
// top level of the polygon point-region classifier
// depends on ppr_pkg, ppr_in_if, ppr_out_if, ppr_issue, ppr_edge, ppr_collect
`timescale 1ns / 1ps

// usage
// - query channel carries command (clear, append vertex, classify point) with
//   point_x / point_y in signed Q16.16; answer channel returns one item per
//   query item: region, polygon_valid and status, in query order
// - clear and append items issue a single token; a classify whose point
//   lies in the bounding box issues one token per polygon edge, n being
//   the number of stored vertices (up to 32); a point outside the box, or
//   any item with no vertices stored, issues a single token
// - the issue rate is set by the single read port of the vertex store, which
//   feeds one edge per cycle into the crossing pipeline unless stalled
// - pipeline: sequencer, vertex read, edge deltas, exact 33x33 products,
//   crossing compare, parity and result register
// - reset empties the pipeline, zeroes the vertex count and bounding box;
//   vertex store contents stay undefined; no unwritten entry affects an answer
// - when the receiver stalls the whole pipeline holds in place and the
//   query channel drops ready; nothing is lost or repeated
module polygon_point_region_classifier (
    input  logic     clk,
    input  logic     rst_n,
    ppr_in_if.sink   query,
    ppr_out_if.source answer
);

    logic               en;
    logic               s1_valid;
    ppr_pkg::tag_t      s1_tag;
    ppr_pkg::edge_pts_t s1_pts;
    logic               s4_valid;
    ppr_pkg::tag_t      s4_tag;
    logic               s4_cross;

    // polygon state, vertex store, edge sequencer
    ppr_issue u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .query    (query),
        .s1_valid (s1_valid),
        .s1_tag   (s1_tag),
        .s1_pts   (s1_pts)
    );

    // per-edge crossing test
    ppr_edge u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s1_valid (s1_valid),
        .s1_tag   (s1_tag),
        .s1_pts   (s1_pts),
        .s4_valid (s4_valid),
        .s4_tag   (s4_tag),
        .s4_cross (s4_cross)
    );

    // parity and output register; drives the pipeline enable
    ppr_collect u_collect (
        .clk      (clk),
        .rst_n    (rst_n),
        .s4_valid (s4_valid),
        .s4_tag   (s4_tag),
        .s4_cross (s4_cross),
        .en       (en),
        .answer   (answer)
    );

endmodule
